// ----- rtl/core/ptpm_pkg.sv -----
// Shared types and codes for the parameter table priority match block.
package ptpm_pkg;

  // Width of the packed input fields (without padding) and padded bus widths.
  localparam int IN_FLD_W    = 75;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 8;
  localparam int IDX_OUT_W   = 6;

  // Item mode, carried on in_tuser.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result status, carried on out_tuser.
  localparam logic [1:0] STAT_STORED = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_MATCH  = 2'd2;
  localparam logic [1:0] STAT_NONE   = 2'd3;

  // Match kinds.
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PARTIAL = 2'd1;
  localparam logic [1:0] KIND_EXACT   = 2'd2;

  // One stored table entry (64 bits).
  typedef struct packed {
    logic [7:0]  disc;
    logic [7:0]  cat;
    logic [7:0]  num;
    logic [7:0]  vlo;
    logic [7:0]  vhi;
    logic [15:0] center;
    logic [7:0]  lcl;
  } entry_t;

  // Query held for the length of a scan.
  typedef struct packed {
    logic [7:0]  disc;
    logic [7:0]  cat;
    logic [7:0]  num;
    logic [7:0]  qver;
    logic [15:0] center;
    logic [7:0]  lcl;
    logic        vg;
    logic        cg;
    logic        lg;
  } query_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN1,
    ST_SCAN2,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/core/parameter_table_priority_match.sv -----
// Parameter table with priority match: top level, sequencer and output register.
//
// Keeps up to TABLE_DEPTH parameter entries and answers lookups against them.
// A load transfer (in_tuser = 0) appends an entry and answers one result with
// status 0, or status 1 if the table is already full. A query transfer
// (in_tuser = 1) is compared against every stored entry with keys equal to
// the query's discipline, category and number. Exact matches are reported
// one transfer each, in table order; if there are none, partial matches are
// reported instead; if there are neither, a single status 3 result is given.
// out_tlast marks the final result of each item.
// A load passes through the LOAD state. For a query the single shared compare
// unit walks the entry memory once to look for any exact match and once more
// to report, one entry per cycle through the memory's registered read port
// while the output side does not stall, each walk ending by draining the read
// pipeline and seeing it empty. Backpressure on the result side stretches the
// second walk and the final result. in_tready is high only while no item is
// in progress; a result left waiting in the output register does not block
// the next transfer from being taken.
module parameter_table_priority_match #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, lowest bit up: discipline[7:0], category[15:8], param_number[23:16],
  // version_low[31:24], version_high[39:32], center_id[55:40],
  // local_table[63:56], query_version[71:64], version_given[72],
  // center_given[73], local_given[74], zero pad[79:75]
  input  logic [ptpm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,   // mode
  // Result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, lowest bit up: entry_index[5:0], match_kind[7:6]
  output logic [ptpm_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                       out_tuser,  // status
  output logic                             out_tlast   // is_last
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Sequencer state
  ptpm_pkg::state_t state_r, state_nxt;

  // Fill count and scan pointer
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ctr_r, ctr_nxt;

  // Read data tag: entry index whose data sits on the memory output
  logic          d_vld_r, d_vld_nxt;
  logic [IW-1:0] d_idx_r, d_idx_nxt;

  // Pass one result and the kind reported in pass two
  logic          any_exact_r, any_exact_nxt;
  logic [1:0]    want_r, want_nxt;

  // One-deep hold so the last hit can be flagged with tlast
  logic          pend_vld_r, pend_vld_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;

  // Captured input payload
  logic [ptpm_pkg::IN_FLD_W-1:0] in_data_r, in_data_nxt;

  // Output register
  logic          out_vld_r, out_vld_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;
  logic [IW-1:0] out_idx_r, out_idx_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic          out_last_r, out_last_nxt;

  // Memory and compare unit hookup
  ptpm_pkg::entry_t ld_ent;
  ptpm_pkg::query_t qry;
  ptpm_pkg::entry_t rd_ent;
  logic             wr_en;
  logic             rd_en;
  logic [1:0]       kind;

  logic acc;
  logic out_free;
  logic scanning;
  logic scan_done;
  logic issue;
  logic hit;
  logic stall;
  logic full;

  // Field unpacking from the captured payload
  assign ld_ent.disc   = in_data_r[7:0];
  assign ld_ent.cat    = in_data_r[15:8];
  assign ld_ent.num    = in_data_r[23:16];
  assign ld_ent.vlo    = in_data_r[31:24];
  assign ld_ent.vhi    = in_data_r[39:32];
  assign ld_ent.center = in_data_r[55:40];
  assign ld_ent.lcl    = in_data_r[63:56];

  assign qry.disc   = in_data_r[7:0];
  assign qry.cat    = in_data_r[15:8];
  assign qry.num    = in_data_r[23:16];
  assign qry.qver   = in_data_r[71:64];
  assign qry.center = in_data_r[55:40];
  assign qry.lcl    = in_data_r[63:56];
  assign qry.vg     = in_data_r[72];
  assign qry.cg     = in_data_r[73];
  assign qry.lg     = in_data_r[74];

  ptpm_store #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[IW-1:0]),
    .wr_data (ld_ent),
    .rd_en   (rd_en),
    .rd_addr (ctr_r[IW-1:0]),
    .rd_data (rd_ent)
  );

  ptpm_cmp u_cmp (
    .ent  (rd_ent),
    .qry  (qry),
    .kind (kind)
  );

  assign in_tready = (state_r == ptpm_pkg::ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  assign scanning  = (state_r == ptpm_pkg::ST_SCAN1) || (state_r == ptpm_pkg::ST_SCAN2);
  assign scan_done = (ctr_r == cnt_r) && !d_vld_r;
  assign full      = (cnt_r == CW'(TABLE_DEPTH));

  // Pass two: a hit with one already held needs the output register free
  assign hit   = (state_r == ptpm_pkg::ST_SCAN2) && d_vld_r && (kind == want_r);
  assign stall = hit && pend_vld_r && !out_free;
  assign issue = scanning && !stall && (ctr_r != cnt_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptpm_pkg::ST_IDLE: begin
        if (acc) begin
          state_nxt = (in_tuser == ptpm_pkg::MODE_QUERY) ? ptpm_pkg::ST_SCAN1
                                                         : ptpm_pkg::ST_LOAD;
        end
      end
      ptpm_pkg::ST_LOAD: begin
        if (out_free) begin
          state_nxt = ptpm_pkg::ST_IDLE;
        end
      end
      ptpm_pkg::ST_SCAN1: begin
        if (scan_done) begin
          state_nxt = ptpm_pkg::ST_SCAN2;
        end
      end
      ptpm_pkg::ST_SCAN2: begin
        if (scan_done) begin
          state_nxt = ptpm_pkg::ST_FINISH;
        end
      end
      ptpm_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = ptpm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptpm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    ctr_nxt       = ctr_r;
    d_vld_nxt     = d_vld_r;
    d_idx_nxt     = d_idx_r;
    any_exact_nxt = any_exact_r;
    want_nxt      = want_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    in_data_nxt   = in_data_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_idx_nxt   = out_idx_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    rd_en         = issue;

    // Read pipeline advances whenever the scan is not held
    if (scanning && !stall) begin
      d_vld_nxt = issue;
      if (issue) begin
        ctr_nxt   = ctr_r + CW'(1);
        d_idx_nxt = ctr_r[IW-1:0];
      end
    end

    case (state_r)
      ptpm_pkg::ST_IDLE: begin
        if (acc) begin
          in_data_nxt   = in_tdata[ptpm_pkg::IN_FLD_W-1:0];
          ctr_nxt       = '0;
          d_vld_nxt     = 1'b0;
          any_exact_nxt = 1'b0;
          pend_vld_nxt  = 1'b0;
        end
      end
      ptpm_pkg::ST_LOAD: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_idx_nxt  = '0;
          out_kind_nxt = ptpm_pkg::KIND_NONE;
          out_last_nxt = 1'b1;
          if (full) begin
            out_stat_nxt = ptpm_pkg::STAT_FULL;
          end else begin
            out_stat_nxt = ptpm_pkg::STAT_STORED;
            wr_en        = 1'b1;
            cnt_nxt      = cnt_r + CW'(1);
          end
        end
      end
      ptpm_pkg::ST_SCAN1: begin
        if (d_vld_r && (kind == ptpm_pkg::KIND_EXACT)) begin
          any_exact_nxt = 1'b1;
        end
        if (scan_done) begin
          ctr_nxt  = '0;
          want_nxt = any_exact_r ? ptpm_pkg::KIND_EXACT : ptpm_pkg::KIND_PARTIAL;
        end
      end
      ptpm_pkg::ST_SCAN2: begin
        if (hit && !stall) begin
          // Older held hit goes out, this one is held until the next hit or the finish
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_stat_nxt = ptpm_pkg::STAT_MATCH;
            out_idx_nxt  = pend_idx_r;
            out_kind_nxt = want_r;
            out_last_nxt = 1'b0;
          end
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = d_idx_r;
        end
      end
      ptpm_pkg::ST_FINISH: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          if (pend_vld_r) begin
            out_stat_nxt = ptpm_pkg::STAT_MATCH;
            out_idx_nxt  = pend_idx_r;
            out_kind_nxt = want_r;
          end else begin
            out_stat_nxt = ptpm_pkg::STAT_NONE;
            out_idx_nxt  = '0;
            out_kind_nxt = ptpm_pkg::KIND_NONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptpm_pkg::ST_IDLE;
      cnt_r       <= '0;
      ctr_r       <= '0;
      d_vld_r     <= 1'b0;
      any_exact_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ctr_r       <= ctr_nxt;
      d_vld_r     <= d_vld_nxt;
      any_exact_r <= any_exact_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    d_idx_r    <= d_idx_nxt;
    want_r     <= want_nxt;
    pend_idx_r <= pend_idx_nxt;
    in_data_r  <= in_data_nxt;
    out_stat_r <= out_stat_nxt;
    out_idx_r  <= out_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_kind_r, ptpm_pkg::IDX_OUT_W'(out_idx_r)};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/ptpm_store.sv -----
// Entry memory: one write port, one registered read port.
module ptpm_store #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  ptpm_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_addr,
  output ptpm_pkg::entry_t rd_data
);

  ptpm_pkg::entry_t mem [DEPTH];
  ptpm_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/ptpm_cmp.sv -----
// Shared compare unit: classifies one entry against the held query.
module ptpm_cmp (
  input  ptpm_pkg::entry_t ent,
  input  ptpm_pkg::query_t qry,
  output logic [1:0]       kind
);

  logic key_ok;
  logic ver_ok;
  logic none_given;
  logic same_site;
  logic generic;

  assign key_ok     = (ent.disc == qry.disc) && (ent.cat == qry.cat) && (ent.num == qry.num);
  assign ver_ok     = !qry.vg || ((ent.vlo <= qry.qver) && (ent.vhi >= qry.qver));
  assign none_given = !qry.vg && !qry.cg && !qry.lg;
  assign same_site  = qry.cg && qry.lg && (ent.center == qry.center) && (ent.lcl == qry.lcl);
  assign generic    = (ent.center == 16'd0) && (ent.lcl == 8'd0);

  always_comb begin
    if (!key_ok) begin
      kind = ptpm_pkg::KIND_NONE;
    end else if (none_given) begin
      kind = ptpm_pkg::KIND_PARTIAL;
    end else if (ver_ok && same_site) begin
      kind = ptpm_pkg::KIND_EXACT;
    end else if (ver_ok && generic) begin
      kind = ptpm_pkg::KIND_PARTIAL;
    end else begin
      kind = ptpm_pkg::KIND_NONE;
    end
  end

endmodule

// ----- test/tb.sv -----
// Testbench for parameter_table_priority_match: directed and random loads and queries.
module tb;

  localparam int DEPTH       = 64;   // table size the block is built with
  localparam int RAND_ITEMS  = 210;
  localparam int HOLD_CYCLES = 600;  // long result-side stall, fills the block
  localparam int HOLD_AT     = 40;   // result count that triggers the stall
  localparam int DRAIN_WAIT  = 300;  // longer than one full-table query

  // One input item, all fields kept even where the mode ignores them.
  typedef struct packed {
    logic        mode;
    logic [7:0]  disc;
    logic [7:0]  cat;
    logic [7:0]  num;
    logic [7:0]  vlo;
    logic [7:0]  vhi;
    logic [15:0] center;
    logic [7:0]  lcl;
    logic [7:0]  qver;
    logic        vg;
    logic        cg;
    logic        lg;
  } item_t;

  // One stored parameter entry.
  typedef struct packed {
    logic [7:0]  disc;
    logic [7:0]  cat;
    logic [7:0]  num;
    logic [7:0]  vlo;
    logic [7:0]  vhi;
    logic [15:0] center;
    logic [7:0]  lcl;
  } param_rec_t;

  // One result transfer.
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] idx;
    logic [1:0] kind;
    logic       last;
  } answer_t;

  logic                             clk;
  logic                             rst_n     = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [ptpm_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                             in_tuser  = ptpm_pkg::MODE_LOAD;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [ptpm_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]                       out_tuser;
  logic                             out_tlast;

  // Shadow of the block's table and the answers it still owes.
  param_rec_t  param_table [DEPTH];
  int unsigned table_fill = 0;
  answer_t     answers_due [$];
  item_t       pending [$];      // items not yet transferred
  item_t       loaded [$];       // load history, seeds well-formed queries
  int          mismatches = 0;

  // Handshake pacing state.
  int send_wait     = 0;
  int send_burst    = 0;
  int recv_wait     = 0;
  int recv_burst    = 0;
  int results_taken = 0;

  parameter_table_priority_match #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------
  // Bus packing: discipline in the low byte up to local_given at bit 74,
  // bits 79:75 zero.
  // ---------------------------------------------------------------------
  function automatic logic [ptpm_pkg::IN_TDATA_W-1:0] pack_item(item_t it);
    return {5'b0, it.lg, it.cg, it.vg, it.qver, it.lcl, it.center,
            it.vhi, it.vlo, it.num, it.cat, it.disc};
  endfunction

  function automatic item_t unpack_item(logic [ptpm_pkg::IN_TDATA_W-1:0] d, logic m);
    item_t it;
    it.mode   = m;
    it.disc   = d[7:0];
    it.cat    = d[15:8];
    it.num    = d[23:16];
    it.vlo    = d[31:24];
    it.vhi    = d[39:32];
    it.center = d[55:40];
    it.lcl    = d[63:56];
    it.qver   = d[71:64];
    it.vg     = d[72];
    it.cg     = d[73];
    it.lg     = d[74];
    return it;
  endfunction

  // Builders; fields the mode ignores still get random values so every
  // field bit on the bus toggles.
  function automatic item_t load_item(logic [23:0] keys, logic [7:0] vlo,
                                      logic [7:0] vhi, logic [15:0] center,
                                      logic [7:0] lcl);
    item_t it;
    it.mode                 = ptpm_pkg::MODE_LOAD;
    {it.disc, it.cat, it.num} = keys;
    it.vlo                  = vlo;
    it.vhi                  = vhi;
    it.center               = center;
    it.lcl                  = lcl;
    it.qver                 = 8'($urandom_range(0, 255));
    {it.vg, it.cg, it.lg}   = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic item_t query_item(logic [23:0] keys, logic [7:0] qver,
                                       logic [15:0] center, logic [7:0] lcl,
                                       logic vg, logic cg, logic lg);
    item_t it;
    it.mode                 = ptpm_pkg::MODE_QUERY;
    {it.disc, it.cat, it.num} = keys;
    it.vlo                  = 8'($urandom_range(0, 255));
    it.vhi                  = 8'($urandom_range(0, 255));
    it.center               = center;
    it.lcl                  = lcl;
    it.qver                 = qver;
    it.vg                   = vg;
    it.cg                   = cg;
    it.lg                   = lg;
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  // How one entry (keys already equal) relates to a query.
  function automatic logic [1:0] match_kind_of(param_rec_t e, item_t q);
    // no optional key at all: every key-equal entry is a fallback
    if (!q.vg && !q.cg && !q.lg) return ptpm_pkg::KIND_PARTIAL;
    // version absent or inside the range (an inverted range never holds)
    if (!q.vg || (e.vlo <= q.qver && e.vhi >= q.qver)) begin
      if (q.cg && q.lg && e.center == q.center && e.lcl == q.lcl)
        return ptpm_pkg::KIND_EXACT;
      if (e.center == '0 && e.lcl == '0) return ptpm_pkg::KIND_PARTIAL;  // generic entry
    end
    return ptpm_pkg::KIND_NONE;
  endfunction

  function automatic void predict_answers(item_t it);
    param_rec_t e;
    answer_t    a;
    logic [1:0] want;
    int         hits;
    a = '0;
    if (it.mode == ptpm_pkg::MODE_LOAD) begin
      a.last = 1'b1;
      if (table_fill >= DEPTH) begin
        a.status = ptpm_pkg::STAT_FULL;       // full table: nothing stored
      end else begin
        param_table[table_fill] = '{it.disc, it.cat, it.num, it.vlo, it.vhi,
                                    it.center, it.lcl};
        table_fill++;
        a.status = ptpm_pkg::STAT_STORED;
      end
      answers_due.push_back(a);
    end else begin
      // exact matches take priority over partials
      want = ptpm_pkg::KIND_PARTIAL;
      for (int i = 0; i < table_fill; i++) begin
        e = param_table[i];
        if ({e.disc, e.cat, e.num} == {it.disc, it.cat, it.num} &&
            match_kind_of(e, it) == ptpm_pkg::KIND_EXACT) want = ptpm_pkg::KIND_EXACT;
      end
      hits = 0;
      for (int i = 0; i < table_fill; i++) begin
        e = param_table[i];
        if ({e.disc, e.cat, e.num} == {it.disc, it.cat, it.num} &&
            match_kind_of(e, it) == want) begin
          a.status = ptpm_pkg::STAT_MATCH;
          a.idx    = i[5:0];
          a.kind   = want;
          a.last   = 1'b0;
          answers_due.push_back(a);
          hits++;
        end
      end
      if (hits == 0) begin
        // empty table or nothing matching: one no-match answer
        a.status = ptpm_pkg::STAT_NONE;
        a.last   = 1'b1;
        answers_due.push_back(a);
      end else begin
        answers_due[answers_due.size() - 1].last = 1'b1;
      end
    end
  endfunction

  // Idle draw: a uniformly drawn gap between transfers, with occasional
  // stretches of back-to-back transfers.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 30);
    return $urandom_range(0, 11);
  endfunction

  function automatic void note_mismatch(answer_t got, answer_t want, bit unexpected);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected)
        $display("unexpected result: status %0d idx %0d kind %0d last %0d",
                 got.status, got.idx, got.kind, got.last);
      else
        $display({"result mismatch: status %0d/%0d idx %0d/%0d kind %0d/%0d ",
                  "last %0d/%0d (got/exp)"},
                 got.status, want.status, got.idx, want.idx, got.kind, want.kind,
                 got.last, want.last);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents the head of the pending queue, one transfer per item.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    logic  vld;
    item_t head;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= ptpm_pkg::MODE_LOAD;
    end else begin
      vld = in_tvalid;
      if (in_tvalid && in_tready) begin
        head      = pending.pop_front();
        vld       = 1'b0;
        send_wait = draw_gap(send_burst);
      end
      if (!vld && pending.size() != 0) begin
        if (send_wait == 0) vld = 1'b1;
        else send_wait--;
      end
      in_tvalid <= vld;  // single assignment per edge, no drop-and-raise
      if (vld) begin
        head = pending[0];
        in_tdata <= pack_item(head);
        in_tuser <= head.mode;
      end
    end
  end

  // Input monitor: every accepted transfer feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_answers(unpack_item(in_tdata, in_tuser));
  end

  // ---------------------------------------------------------------------
  // Result side: ready drawn per result; one long hold-off lets the input
  // back up while the sender keeps offering.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : accept_results
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rdy = out_tready;
      if (out_tvalid && out_tready) begin
        rdy = 1'b0;
        results_taken++;
        recv_wait = (results_taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(recv_burst);
      end
      if (!rdy) begin
        if (recv_wait == 0) rdy = 1'b1;
        else recv_wait--;
      end
      out_tready <= rdy;
    end
  end

  // Output monitor: each transfer against the oldest expected answer.
  always @(posedge clk) begin : check_results
    answer_t got;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[5:0], out_tdata[7:6], out_tlast};
      if (answers_due.size() == 0) begin
        note_mismatch(got, got, 1'b1);
      end else begin
        want = answers_due.pop_front();
        if (got.status !== want.status || got.idx !== want.idx ||
            got.kind !== want.kind || got.last !== want.last)
          note_mismatch(got, want, 1'b0);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [23:0] key_pool [4];
    logic [15:0] center_pool [3];
    logic [23:0] k1;
    logic [23:0] k2;
    logic [23:0] k0;
    logic [23:0] keys;
    logic [7:0]  vlo;
    logic [7:0]  vhi;
    logic [7:0]  qver;
    logic [15:0] center;
    logic [7:0]  lcl;
    item_t       src;
    int          loads_made;

    k1 = 24'h123456;
    k2 = 24'hFFFFFF;
    k0 = 24'h000000;

    // Directed: empty table first, then a small hand-built table.
    pending.push_back(query_item(k1, 8'd7, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    pending.push_back(load_item(k1, 8'd0,  8'd255, 16'h0000, 8'h00)); // 0 generic, all versions
    pending.push_back(load_item(k1, 8'd5,  8'd10,  16'hFFFF, 8'hFF)); // 1 specific
    pending.push_back(load_item(k1, 8'd10, 8'd5,   16'h0007, 8'h03)); // 2 inverted range
    pending.push_back(load_item(k2, 8'd0,  8'd255, 16'h8001, 8'h80)); // 3 other keys
    pending.push_back(load_item(k0, 8'd0,  8'd0,   16'h0000, 8'h00)); // 4 all-zero keys
    pending.push_back(load_item(k1, 8'd20, 8'd30,  16'h0000, 8'h00)); // 5 generic, narrow
    pending.push_back(load_item(k1, 8'd255, 8'd255, 16'h0000, 8'h01)); // 6 center 0, local set
    // no optional key: every key-equal entry comes back as partial
    pending.push_back(query_item(k1, 8'd0, 16'h0, 8'h0, 1'b0, 1'b0, 1'b0));
    // all given, inside range: exact hit on entry 1 only
    pending.push_back(query_item(k1, 8'd7, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    // version outside entry 1: falls back to generic entry 0
    pending.push_back(query_item(k1, 8'd50, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    // center only, local absent: cannot be exact
    pending.push_back(query_item(k1, 8'd7, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0));
    // version only: generic entries whose range holds 25
    pending.push_back(query_item(k1, 8'd25, 16'h0, 8'h0, 1'b1, 1'b0, 1'b0));
    // version absent: inverted range entry 2 still exact
    pending.push_back(query_item(k1, 8'd0, 16'h0007, 8'h03, 1'b0, 1'b1, 1'b1));
    // version given: inverted range never passes
    pending.push_back(query_item(k1, 8'd7, 16'h0007, 8'h03, 1'b1, 1'b1, 1'b1));
    // top of the version range
    pending.push_back(query_item(k1, 8'd255, 16'h0000, 8'h01, 1'b1, 1'b1, 1'b1));
    pending.push_back(query_item(k2, 8'd0, 16'h0, 8'h0, 1'b0, 1'b0, 1'b0));
    pending.push_back(query_item(k0, 8'd0, 16'h0, 8'h0, 1'b1, 1'b1, 1'b1));
    // keys that no entry has
    pending.push_back(query_item(24'hABCDEF, 8'd0, 16'h0, 8'h0, 1'b0, 1'b0, 1'b0));
    loads_made = 7;

    key_pool[0]    = k0;
    key_pool[1]    = k2;
    key_pool[2]    = k1;
    key_pool[3]    = 24'($urandom);
    center_pool[0] = 16'hFFFF;
    center_pool[1] = 16'($urandom_range(1, 65535));
    center_pool[2] = 16'($urandom_range(1, 65535));

    // Random: keys mostly from a small pool so queries hit; queries mostly
    // built from earlier loads; enough loads to run past a full table.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 45 || (loads_made < 72 && n >= 140)) begin
        keys = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 3)]
                                            : 24'($urandom);
        case ($urandom_range(0, 5))
          0, 1: begin center = '0; lcl = '0; end
          2: begin center = '0; lcl = 8'($urandom_range(1, 255)); end
          3: begin center = center_pool[$urandom_range(0, 2)]; lcl = '0; end
          4: begin
            center = center_pool[$urandom_range(0, 2)];
            lcl    = 8'($urandom_range(1, 3));
          end
          default: begin center = 16'($urandom); lcl = 8'($urandom); end
        endcase
        vlo = 8'($urandom_range(0, 255));
        vhi = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(vlo, 255))
                                          : 8'($urandom_range(0, 255));
        src = load_item(keys, vlo, vhi, center, lcl);
        pending.push_back(src);
        loaded.push_back(src);
        loads_made++;
      end else if (loaded.size() != 0 && $urandom_range(0, 99) < 85) begin
        src = loaded[$urandom_range(0, loaded.size() - 1)];
        if ($urandom_range(0, 9) < 7) begin
          center = src.center;
          lcl    = src.lcl;
        end else begin
          center = center_pool[$urandom_range(0, 2)];
          lcl    = 8'($urandom);
        end
        if ($urandom_range(0, 4) != 0 && src.vlo <= src.vhi)
          qver = 8'($urandom_range(src.vlo, src.vhi));
        else
          qver = 8'($urandom_range(0, 255));
        pending.push_back(query_item({src.disc, src.cat, src.num}, qver, center, lcl,
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1))));
      end else begin
        // noise query
        pending.push_back(query_item(24'($urandom), 8'($urandom), 16'($urandom),
                                     8'($urandom), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end
    end

    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0) @(posedge clk);
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ptpm_pkg.sv
rtl/core/ptpm_store.sv
rtl/core/ptpm_cmp.sv
rtl/core/parameter_table_priority_match.sv
test/tb.sv
